>>> design/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/skvt_pkg.sv
// Types and codes shared by the sorted key/value table modules.
// Depends on nothing.
package skvt_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ENTRY = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;
        logic reject;
        logic dump_empty;
        logic dump_step;
    } skvt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic dump_last;
    } skvt_stat_t;

endpackage

>>> design/sorted_key_value_table.sv
// Top level of the sorted key/value table: controller plus cell-chain datapath.
// Depends on skvt_pkg, skvt_controller and skvt_datapath.
//
//  Channel  | Handshake           | Fields
//  ---------+---------------------+------------------------------------------
//  command  | start high, busy low| op, key, payload
//  result   | done, one cycle     | out_key, out_payload, last_flag, status
//
// An insert's status result shows on the next cycle and a new command may be
// given in that same cycle, as the compare-and-shift chain does it.
// A dump keeps busy high while the controller is in its dump state and streams one
// entry per cycle from the head cell of the rotating chain, each through the result
// registers after that state is entered; an empty dump answers on the next cycle.
// Reset clears the entry count and the controller; the cells are not cleared.
// The receiver cannot stall: every result is valid for exactly one cycle.
module sorted_key_value_table
    import skvt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic signed [31:0] key,
    input  logic signed [31:0] payload,
    output logic               done,
    output logic signed [31:0] out_key,
    output logic signed [31:0] out_payload,
    output logic               last_flag,
    output logic [1:0]         status
);

    skvt_cmd_t  cmd;
    skvt_stat_t stat;
    status_t    status_int;

    skvt_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    skvt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key         (key),
        .payload     (payload),
        .stat        (stat),
        .done        (done),
        .out_key     (out_key),
        .out_payload (out_payload),
        .last_flag   (last_flag),
        .status      (status_int)
    );

    assign status = status_int;

endmodule

>>> design/skvt_datapath.sv
// Datapath of the sorted key/value table: a chain of compare-and-shift cells,
// the entry count, the dump index and the result registers. Depends on skvt_pkg.
module skvt_datapath
    import skvt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  skvt_cmd_t          cmd,
    input  logic signed [31:0] key,
    input  logic signed [31:0] payload,
    output skvt_stat_t         stat,
    output logic               done,
    output logic signed [31:0] out_key,
    output logic signed [31:0] out_payload,
    output logic               last_flag,
    output status_t            status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic signed [31:0] key_reg  [CAPACITY];
    logic signed [31:0] pay_reg  [CAPACITY];
    logic signed [31:0] key_next [CAPACITY];
    logic signed [31:0] pay_next [CAPACITY];
    logic [CAPACITY-1:0] ge;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] last_idx;

    logic               done_reg, done_next;
    logic signed [31:0] out_key_reg, out_key_next;
    logic signed [31:0] out_pay_reg, out_pay_next;
    logic               last_reg, last_next;
    status_t            status_reg, status_next;

    assign last_idx = count_reg - CNT_W'(1);

    // A cell past the fill level counts as "greater or equal", so a key larger
    // than every stored one lands right at the end of the filled part.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            // Neighbor indexes, kept inside the array at both ends of the chain.
            localparam int PREV = (gi == 0) ? 0 : gi - 1;
            localparam int NEXT = (gi == CAPACITY - 1) ? 0 : gi + 1;

            assign ge[gi] = (CNT_W'(gi) >= count_reg) || (key_reg[gi] >= key);

            always_comb
            begin
                key_next[gi] = key_reg[gi];
                pay_next[gi] = pay_reg[gi];
                if (cmd.insert)
                begin
                    if (gi == 0)
                    begin
                        if (ge[gi])
                        begin
                            key_next[gi] = key;
                            pay_next[gi] = payload;
                        end
                    end
                    else
                    begin
                        if (ge[gi] && !ge[PREV])
                        begin
                            key_next[gi] = key;
                            pay_next[gi] = payload;
                        end
                        else if (ge[gi])
                        begin
                            key_next[gi] = key_reg[PREV];
                            pay_next[gi] = pay_reg[PREV];
                        end
                    end
                end
                else if (cmd.dump_step)
                begin
                    // Rotate the filled part by one; after count steps it is restored.
                    if (gi == CAPACITY - 1)
                    begin
                        key_next[gi] = key_reg[0];
                        pay_next[gi] = pay_reg[0];
                    end
                    else if (CNT_W'(gi) == last_idx)
                    begin
                        key_next[gi] = key_reg[0];
                        pay_next[gi] = pay_reg[0];
                    end
                    else
                    begin
                        key_next[gi] = key_reg[NEXT];
                        pay_next[gi] = pay_reg[NEXT];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                key_reg[gi] <= key_next[gi];
                pay_reg[gi] <= pay_next[gi];
            end
        end
    endgenerate

    assign stat.full      = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty     = (count_reg == '0);
    assign stat.dump_last = (idx_reg == last_idx[IDX_W-1:0]);

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.dump_step)
        begin
            idx_next = stat.dump_last ? '0 : idx_reg + IDX_W'(1);
        end

        done_next    = cmd.insert | cmd.reject | cmd.dump_empty | cmd.dump_step;
        out_key_next = '0;
        out_pay_next = '0;
        last_next    = 1'b1;
        status_next  = ST_OK;
        if (cmd.reject)
        begin
            status_next = ST_FULL;
        end
        else if (cmd.dump_empty)
        begin
            status_next = ST_EMPTY;
        end
        else if (cmd.dump_step)
        begin
            status_next  = ST_ENTRY;
            out_key_next = key_reg[0];
            out_pay_next = pay_reg[0];
            last_next    = stat.dump_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_key_reg <= out_key_next;
        out_pay_reg <= out_pay_next;
        last_reg    <= last_next;
        status_reg  <= status_next;
    end

    assign done        = done_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_pay_reg;
    assign last_flag   = last_reg;
    assign status      = status_reg;

endmodule

>>> design/skvt_controller.sv
// Controller of the sorted key/value table: accepts commands and sequences dumps.
// Depends on skvt_pkg.
module skvt_controller
    import skvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       op,
    input  skvt_stat_t stat,
    output skvt_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!op)
                    begin
                        cmd.insert = !stat.full;
                        cmd.reject = stat.full;
                    end
                    else if (stat.empty)
                    begin
                        cmd.dump_empty = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DUMP;
                    end
                end
            end
            S_DUMP:
            begin
                busy          = 1'b1;
                cmd.dump_step = 1'b1;
                if (stat.dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/skvt_checker.sv
// Port-level checker for the sorted key/value table, bound to the top level.
// Depends on skvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module skvt_checker
    import skvt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               op,
    input logic               done,
    input logic signed [31:0] out_key,
    input logic signed [31:0] out_payload,
    input logic               last_flag,
    input logic [1:0]         status
);

    // Every transaction other than a dump entry is a single, final result.
    `ASSERT_IMPL(a_single_last, done && (status != ST_ENTRY), last_flag, "status not last")

    `ASSERT_IMPL(a_zero_fields, done && (status != ST_ENTRY), (out_key == 0) && (out_payload == 0), "data")

    `ASSERT_NEXT(a_insert_answer, start && !busy && !op, done && last_flag && (status <= ST_FULL), "insert")

    // A dump either answers empty at once or holds busy while it streams entries.
    `ASSERT_NEXT(a_dump_answer, start && !busy && op, busy || (done && (status == ST_EMPTY)), "dump")

    // Once the final result of a transaction shows, the table is free again.
    `ASSERT_IMPL(a_free_after_last, done && last_flag, !busy, "busy after final result")

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted key/value table (sorted_key_value_table).
// Depends on skvt_pkg and the design files; a directed table runs first, then
// random commands, scored against an in-bench sorted-table model or typed results.
module testbench;
    import skvt_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_TAIL  = 100;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_LIMIT = 40;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef struct {
        logic signed [31:0] key;
        logic signed [31:0] payload;
        logic               last;
        status_t            status;
    } result_t;

    typedef struct {
        logic               op;
        logic signed [31:0] key;
        logic signed [31:0] payload;
        bit                 fixed;
        result_t            want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               op;
    logic signed [31:0] key;
    logic signed [31:0] payload;
    logic               done;
    logic signed [31:0] out_key;
    logic signed [31:0] out_payload;
    logic               last_flag;
    logic [1:0]         status;

    // Expectation that travels with the command when a directed row types it in.
    bit      cmd_fixed;
    result_t cmd_want;

    // Model of the table contents, kept in ascending key order.
    logic signed [31:0] table_keys [CAPACITY];
    logic signed [31:0] table_payloads [CAPACITY];
    int                 table_count;

    result_t   pending_results[$];
    stim_row_t directed_rows[$];
    int        error_count;
    int        cycle_count;

    sorted_key_value_table #(.CAPACITY(CAPACITY)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .key         (key),
        .payload     (payload),
        .done        (done),
        .out_key     (out_key),
        .out_payload (out_payload),
        .last_flag   (last_flag),
        .status      (status)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Applies one accepted command to the table model and queues its results.
    function automatic void apply_command(input logic cmd_op,
                                          input logic signed [31:0] cmd_key,
                                          input logic signed [31:0] cmd_payload,
                                          input bit fixed, input result_t want);
        result_t r;
        int      pos;
        int      i;
        bit      found;
        result_t produced[$];

        r.key     = '0;
        r.payload = '0;
        r.last    = 1'b1;
        r.status  = ST_OK;
        if (cmd_op == OP_INSERT) begin
            if (table_count >= CAPACITY) begin
                r.status = ST_FULL;
            end
            else begin
                pos   = table_count;
                found = 0;
                for (i = 0; i < table_count; i++) begin
                    if (!found && table_keys[i] >= cmd_key) begin
                        pos   = i;
                        found = 1;
                    end
                end
                for (i = table_count; i > pos; i--) begin
                    table_keys[i]     = table_keys[i - 1];
                    table_payloads[i] = table_payloads[i - 1];
                end
                table_keys[pos]     = cmd_key;
                table_payloads[pos] = cmd_payload;
                table_count++;
            end
            produced.push_back(r);
        end
        else if (table_count == 0) begin
            r.status = ST_EMPTY;
            produced.push_back(r);
        end
        else begin
            for (i = 0; i < table_count; i++) begin
                r.key     = table_keys[i];
                r.payload = table_payloads[i];
                r.last    = (i == table_count - 1);
                r.status  = ST_ENTRY;
                produced.push_back(r);
            end
        end

        if (fixed)
            pending_results.push_back(want);
        else
            foreach (produced[j])
                pending_results.push_back(produced[j]);
    endfunction

    always @(posedge clk) begin
        result_t exp_r;

        if (rst_n) begin
            if (done) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result strobe with no transaction outstanding");
                end
                else begin
                    exp_r = pending_results.pop_front();
                    if (out_key !== exp_r.key)
                        report_mismatch($sformatf("out_key %h, expected %h",
                                                  out_key, exp_r.key));
                    if (out_payload !== exp_r.payload)
                        report_mismatch($sformatf("out_payload %h, expected %h",
                                                  out_payload, exp_r.payload));
                    if (last_flag !== exp_r.last)
                        report_mismatch($sformatf("last_flag %b, expected %b",
                                                  last_flag, exp_r.last));
                    if (status !== exp_r.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, exp_r.status));
                end
            end
            if (start && !busy)
                apply_command(op, key, payload, cmd_fixed, cmd_want);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** sorted_key_value_table: FAILED **");
            $finish;
        end
    end

    // Presents one command and returns at the edge that accepts it.
    task automatic issue_command(input stim_row_t row, input bit allow_idle);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start     <= 1'b1;
        op        <= row.op;
        key       <= row.key;
        payload   <= row.payload;
        cmd_fixed <= row.fixed;
        cmd_want  <= row.want;
        do @(posedge clk); while (busy);
    endtask

    function automatic void add_row(input logic row_op, input logic signed [31:0] k,
                                    input logic signed [31:0] p, input bit fixed,
                                    input status_t st);
        stim_row_t row;

        row.op           = row_op;
        row.key          = k;
        row.payload      = p;
        row.fixed        = fixed;
        row.want.key     = '0;
        row.want.payload = '0;
        row.want.last    = 1'b1;
        row.want.status  = st;
        directed_rows.push_back(row);
    endfunction

    initial begin
        stim_row_t row;
        int        pick;

        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = OP_INSERT;
        key         = '0;
        payload     = '0;
        cmd_fixed   = 0;
        cmd_want    = '{key: '0, payload: '0, last: 1'b0, status: ST_OK};
        table_count = 0;
        error_count = 0;
        cycle_count = 0;

        add_row(OP_DUMP,   32'sh0,        32'sh0,        1, ST_EMPTY);
        add_row(OP_INSERT, 32'sh0,        32'sh0,        1, ST_OK);
        add_row(OP_INSERT, 32'sh7fffffff, 32'shffffffff, 1, ST_OK);
        add_row(OP_INSERT, 32'sh80000000, 32'sh80000000, 1, ST_OK);
        add_row(OP_INSERT, 32'shffffffff, 32'sh7fffffff, 1, ST_OK);
        // Equal keys: the newer pair must come out ahead of the older one.
        add_row(OP_INSERT, 32'sh0,        32'sh1,        1, ST_OK);
        add_row(OP_INSERT, 32'sh80000000, 32'sh1,        1, ST_OK);
        add_row(OP_INSERT, 32'sh7fffffff, 32'sh0,        1, ST_OK);
        add_row(OP_DUMP,   32'sh0,        32'sh0,        0, ST_ENTRY);
        add_row(OP_INSERT, 32'sh1,        32'sh5a5a5a5a, 1, ST_OK);
        add_row(OP_INSERT, 32'shfffffffe, 32'sha5a5a5a5, 1, ST_OK);
        add_row(OP_INSERT, 32'sh64,       32'sh12345678, 1, ST_OK);
        add_row(OP_INSERT, 32'sh5a5a5a5a, 32'sh2,        1, ST_OK);
        add_row(OP_INSERT, 32'sha5a5a5a5, 32'shfffffffe, 1, ST_OK);
        add_row(OP_INSERT, 32'sh0,        32'sh3,        1, ST_OK);
        add_row(OP_INSERT, 32'sh2,        32'sh80000001, 1, ST_OK);
        add_row(OP_INSERT, 32'shffffff9c, 32'sh7ffffffe, 1, ST_OK);
        add_row(OP_INSERT, 32'sh12345678, 32'shedcba987, 1, ST_OK);
        // The table now holds CAPACITY pairs; further inserts are dropped.
        add_row(OP_INSERT, 32'sh3,        32'sh4,        1, ST_FULL);
        add_row(OP_DUMP,   32'sh0,        32'sh0,        0, ST_ENTRY);
        add_row(OP_INSERT, 32'sh80000000, 32'sh5,        1, ST_FULL);
        add_row(OP_DUMP,   32'shffffffff, 32'shffffffff, 0, ST_ENTRY);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            issue_command(directed_rows[i], 1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            row.op      = 1'($urandom_range(0, 1));
            row.key     = $urandom;
            row.payload = $urandom;
            pick = $urandom_range(0, 7);
            if (pick == 0)
                row.key = 32'sh80000000;
            else if (pick == 1)
                row.key = 32'sh7fffffff;
            row.fixed = 0;
            row.want  = '{key: '0, payload: '0, last: 1'b0, status: ST_OK};
            issue_command(row, n < RANDOM_ITEMS - QUIET_TAIL);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("** sorted_key_value_table: PASSED **");
        else
            $display("** sorted_key_value_table: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/skvt_pkg.sv
design/skvt_datapath.sv
design/skvt_controller.sv
design/sorted_key_value_table.sv
design/skvt_checker.sv
verif/testbench.sv
